/* hdl/dpws_pkg.sv */
package dpws_pkg;

    // Field widths
    localparam int unsigned CNT_W    = 16;
    localparam int unsigned WAIT_W   = 6;
    localparam int unsigned SAMPLE_W = 12;
    localparam int unsigned PHCODE_W = 2;
    localparam int unsigned CFG_IDX_W = 2;

    // Default scale of the wait time
    localparam int unsigned MS_PER_SECOND_DEF = 1000;

    // Register reset values
    localparam logic [CNT_W-1:0]  FIRST_TICKS_RST  = CNT_W'(10);
    localparam logic [CNT_W-1:0]  SECOND_TICKS_RST = CNT_W'(0);
    localparam logic [CNT_W-1:0]  GAP_MS_RST       = CNT_W'(10);
    localparam logic [WAIT_W-1:0] WAIT_SEC_RST     = WAIT_W'(1);

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIRST_TICKS  = 2'd0,
        CFG_SECOND_TICKS = 2'd1,
        CFG_GAP_MS       = 2'd2,
        CFG_WAIT_SEC     = 2'd3
    } t_cfg_idx;

    // Weld phase, one-hot
    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_FIRST  = 4'b0010,
        PH_GAP    = 4'b0100,
        PH_SECOND = 4'b1000
    } t_phase;

    // Phase codes as seen on the result port
    localparam logic [PHCODE_W-1:0] CODE_IDLE   = 2'd0;
    localparam logic [PHCODE_W-1:0] CODE_FIRST  = 2'd1;
    localparam logic [PHCODE_W-1:0] CODE_GAP    = 2'd2;
    localparam logic [PHCODE_W-1:0] CODE_SECOND = 2'd3;

    // Next arm state from the trigger tracker
    typedef struct packed {
        logic             armed;
        logic [CNT_W-1:0] wait_ms;
    } t_trig_next;

    // Sequencer status toward the top level
    typedef struct packed {
        t_phase phase;
        logic   cnt_zero;
        logic   drive;
    } t_seq_stat;

    function automatic logic [PHCODE_W-1:0] ph_code(input t_phase ph);
        logic [PHCODE_W-1:0] code;
        unique case (ph)
            PH_FIRST:  code = CODE_FIRST;
            PH_GAP:    code = CODE_GAP;
            PH_SECOND: code = CODE_SECOND;
            default:   code = CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

/* hdl/dpws_trigger.sv */
module dpws_trigger
    import dpws_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic       i_ms,
    input  logic       i_trig,
    input  logic       i_disarm,
    output t_trig_next o_next
);

    logic             r_armed;
    logic             r_prev_trig;
    logic [CNT_W-1:0] r_wait_ms;
    t_trig_next       n_next;

    // Falling edge arms and restarts the wait, released level disarms
    always_comb begin
        n_next.armed   = r_armed;
        n_next.wait_ms = r_wait_ms;
        if (r_prev_trig && !i_trig) begin
            n_next.armed   = 1'b1;
            n_next.wait_ms = '0;
        end else if (i_trig) begin
            n_next.armed = 1'b0;
        end else if (r_armed && i_ms && (r_wait_ms != {CNT_W{1'b1}})) begin
            n_next.wait_ms = r_wait_ms + CNT_W'(1);
        end
    end

    assign o_next = n_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed     <= 1'b0;
            r_prev_trig <= 1'b1;
            r_wait_ms   <= '0;
        end else if (i_step) begin
            r_armed     <= n_next.armed && !i_disarm;
            r_prev_trig <= i_trig;
            r_wait_ms   <= n_next.wait_ms;
        end
    end

endmodule

/* hdl/dpws_phase.sv */
module dpws_phase
    import dpws_pkg::*;
#(
    parameter int unsigned THR_W = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic                i_ms,
    input  logic                i_ptick,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  t_trig_next          i_trig_next,
    input  logic [THR_W-1:0]    i_threshold,
    input  logic [CNT_W-1:0]    i_first_ticks,
    input  logic [CNT_W-1:0]    i_second_ticks,
    input  logic [CNT_W-1:0]    i_gap_ms,
    output logic                o_disarm,
    output t_seq_stat           o_stat,
    output logic [CNT_W-1:0]    o_weld_total,
    output logic [SAMPLE_W-1:0] o_captured
);

    localparam int unsigned CMP_W = (THR_W > CNT_W) ? THR_W : CNT_W;

    t_phase              r_phase, n_phase;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [CNT_W-1:0]    r_weld_count, n_weld_count;
    logic [SAMPLE_W-1:0] r_hold, n_hold;
    logic                tick;
    logic [CNT_W-1:0]    cnt_dec;
    logic                wait_done;
    logic                go_gap;
    logic                go_second;

    // Shared down counter: pulses count pulse ticks, the gap counts ms
    assign tick    = (r_phase == PH_GAP) ? i_ms : i_ptick;
    assign cnt_dec = (tick && (r_cnt != '0)) ? (r_cnt - CNT_W'(1)) : r_cnt;

    assign wait_done = i_trig_next.armed &&
                       (CMP_W'(i_trig_next.wait_ms) >= CMP_W'(i_threshold));

    // Phase sequencing, zero-length phases chain through in the same step
    always_comb begin
        n_phase      = r_phase;
        n_cnt        = r_cnt;
        n_weld_count = r_weld_count;
        n_hold       = r_hold;
        o_disarm     = 1'b0;
        go_gap       = 1'b0;
        go_second    = 1'b0;

        unique case (r_phase)
            PH_FIRST: begin
                n_cnt = cnt_dec;
                if (cnt_dec == '0) go_gap = 1'b1;
            end
            PH_GAP: begin
                n_cnt = cnt_dec;
                if (cnt_dec == '0) go_second = 1'b1;
            end
            PH_SECOND: begin
                n_cnt = cnt_dec;
                if (cnt_dec == '0) n_phase = PH_IDLE;
            end
            default: begin
                if (wait_done) begin
                    o_disarm = 1'b1;
                    if ((i_first_ticks != '0) || (i_second_ticks != '0)) begin
                        n_weld_count = r_weld_count + CNT_W'(1);
                        if (i_first_ticks != '0) begin
                            n_phase = PH_FIRST;
                            n_cnt   = i_first_ticks;
                            n_hold  = i_sample;
                        end else begin
                            go_gap = 1'b1;
                        end
                    end
                end
            end
        endcase

        // Enter gap
        if (go_gap) begin
            if (i_second_ticks == '0) begin
                n_phase = PH_IDLE;
                n_cnt   = '0;
            end else if (i_gap_ms == '0) begin
                go_second = 1'b1;
            end else begin
                n_phase = PH_GAP;
                n_cnt   = i_gap_ms;
            end
        end

        // Enter second pulse
        if (go_second) begin
            if (i_second_ticks != '0) begin
                n_phase = PH_SECOND;
                n_cnt   = i_second_ticks;
                n_hold  = i_sample;
            end else begin
                n_phase = PH_IDLE;
                n_cnt   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_cnt        <= '0;
            r_weld_count <= '0;
            r_hold       <= '0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_cnt        <= n_cnt;
            r_weld_count <= n_weld_count;
            r_hold       <= n_hold;
        end
    end

    assign o_stat.phase    = r_phase;
    assign o_stat.cnt_zero = (r_cnt == '0);
    assign o_stat.drive    = (r_phase == PH_FIRST) || (r_phase == PH_SECOND);
    assign o_weld_total    = r_weld_count;
    assign o_captured      = r_hold;

endmodule

/* hdl/dual_pulse_weld_sequencer.sv */
// Dual-pulse spot-weld timer. One request is one time step (ms strobe, pulse-timer
// strobe, trigger level, current sample) and yields exactly one result showing the
// state after that step. A request is taken every clock while the result side does
// not stall: it is registered in the input register, the arm tracker and phase
// sequencer update in one pass of counters and compares, and the result is held in
// the state registers until taken, so throughput is one request per cycle while
// the result side does not stall. The wait threshold (wait_seconds times
// MS_PER_SECOND) is multiplied out when wait_seconds is written, so the step
// path holds only a compare. The user must write configuration only while no
// request is in flight; the block itself does not enforce this.
module dual_pulse_weld_sequencer
    import dpws_pkg::*;
#(
    parameter int unsigned MS_PER_SECOND = MS_PER_SECOND_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Config write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CNT_W-1:0]     i_cfg_wdata,
    // Request channel
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_ms_strobe,
    input  logic                 i_pulse_strobe,
    input  logic                 i_trigger_level,
    input  logic [SAMPLE_W-1:0]  i_current_sample,
    // Result channel
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_weld_drive,
    output logic                 o_buzzer_drive,
    output logic [CNT_W-1:0]     o_weld_total,
    output logic [SAMPLE_W-1:0]  o_captured_current,
    output logic [PHCODE_W-1:0]  o_phase_now
);

    localparam int unsigned MSPS_W = $clog2(MS_PER_SECOND + 1);
    localparam int unsigned THR_W  = WAIT_W + MSPS_W;

    logic [CNT_W-1:0]    r_first_ticks;
    logic [CNT_W-1:0]    r_second_ticks;
    logic [CNT_W-1:0]    r_gap_ms;
    logic [THR_W-1:0]    r_threshold;

    logic                r_in_valid;
    logic                r_ms;
    logic                r_ptick;
    logic                r_trig;
    logic [SAMPLE_W-1:0] r_sample;
    logic                r_out_valid;

    logic                advance;
    logic                step;
    logic                disarm;
    t_trig_next          trig_next;
    t_seq_stat           stat;

    // Config registers; threshold is multiplied out at write time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_ticks  <= FIRST_TICKS_RST;
            r_second_ticks <= SECOND_TICKS_RST;
            r_gap_ms       <= GAP_MS_RST;
            r_threshold    <= THR_W'(WAIT_SEC_RST) * THR_W'(MS_PER_SECOND);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_FIRST_TICKS:  r_first_ticks  <= i_cfg_wdata;
                CFG_SECOND_TICKS: r_second_ticks <= i_cfg_wdata;
                CFG_GAP_MS:       r_gap_ms       <= i_cfg_wdata;
                CFG_WAIT_SEC:     r_threshold    <=
                    THR_W'(i_cfg_wdata[WAIT_W-1:0]) * THR_W'(MS_PER_SECOND);
                default: ;
            endcase
        end
    end

    // Pipeline flow control
    assign advance = !r_out_valid || !i_stall;
    assign step    = r_in_valid && advance;
    assign o_stall = r_in_valid && !advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_ms     <= i_ms_strobe;
            r_ptick  <= i_pulse_strobe;
            r_trig   <= i_trigger_level;
            r_sample <= i_current_sample;
        end
    end

    // Result valid; the result fields are the state registers themselves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    dpws_trigger u_trigger (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_ms     (r_ms),
        .i_trig   (r_trig),
        .i_disarm (disarm),
        .o_next   (trig_next)
    );

    dpws_phase #(
        .THR_W (THR_W)
    ) u_phase (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_ms           (r_ms),
        .i_ptick        (r_ptick),
        .i_sample       (r_sample),
        .i_trig_next    (trig_next),
        .i_threshold    (r_threshold),
        .i_first_ticks  (r_first_ticks),
        .i_second_ticks (r_second_ticks),
        .i_gap_ms       (r_gap_ms),
        .o_disarm       (disarm),
        .o_stat         (stat),
        .o_weld_total   (o_weld_total),
        .o_captured     (o_captured_current)
    );

    assign o_valid        = r_out_valid;
    assign o_weld_drive   = stat.drive;
    assign o_buzzer_drive = stat.drive;
    assign o_phase_now    = ph_code(stat.phase);

    // Any active phase has time left on its counter
    a_active_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (stat.phase != PH_IDLE) |-> !stat.cnt_zero)
        else $error("active weld phase with expired counter");

    // Weld count only moves on a step that began in idle
    a_count_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!step || (stat.phase != PH_IDLE)) |=> $stable(o_weld_total))
        else $error("weld count changed outside an idle step");

    // Request side only stalls when a result is held back
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_out_valid && i_stall))
        else $error("request stalled with result side free");

    // Held result does not change while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_phase_now)
                                  && $stable(o_captured_current)))
        else $error("stalled result changed");

endmodule

/* tb/dual_pulse_weld_sequencer_checker.sv */
module dual_pulse_weld_sequencer_checker
    import dpws_pkg::*;
#(
    parameter int unsigned MS_PER_SECOND = MS_PER_SECOND_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Config writes as seen by the block
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CNT_W-1:0]     i_cfg_wdata,
    // Request channel
    input  logic                 i_req_valid,
    input  logic                 i_req_stall,
    input  logic                 i_ms_strobe,
    input  logic                 i_pulse_strobe,
    input  logic                 i_trigger_level,
    input  logic [SAMPLE_W-1:0]  i_current_sample,
    // Result channel
    input  logic                 i_res_valid,
    input  logic                 i_res_stall,
    input  logic                 i_weld_drive,
    input  logic                 i_buzzer_drive,
    input  logic [CNT_W-1:0]     i_weld_total,
    input  logic [SAMPLE_W-1:0]  i_captured_current,
    input  logic [PHCODE_W-1:0]  i_phase_now,
    // End of run: anything still queued is a failure
    input  logic                 i_closing,
    output int                   o_fail_count
);

    // What the result port should show after one time step
    typedef struct packed {
        logic                drive;
        logic                buzz;
        logic [CNT_W-1:0]    total;
        logic [SAMPLE_W-1:0] held;
        logic [PHCODE_W-1:0] ph;
    } t_weld_view;

    t_weld_view weld_views[$];
    int         mismatches    = 0;
    logic       leftover_seen = 1'b0;

    // Shadow registers
    logic [CNT_W-1:0]    first_len;
    logic [CNT_W-1:0]    second_len;
    logic [CNT_W-1:0]    gap_len;
    logic [WAIT_W-1:0]   arm_secs;

    // Shadow sequencer state
    logic [PHCODE_W-1:0] phase;
    logic                armed;
    logic                prev_trig;
    logic [CNT_W-1:0]    wait_ms;
    logic [CNT_W-1:0]    phase_cnt;
    logic [CNT_W-1:0]    welds;
    logic [SAMPLE_W-1:0] held_current;

    assign o_fail_count = mismatches;

    // Second pulse entry; its length is read here
    function automatic void start_second(input logic [SAMPLE_W-1:0] smp);
        if (second_len != '0) begin
            phase        = CODE_SECOND;
            phase_cnt    = second_len;
            held_current = smp;
        end else begin
            phase     = CODE_IDLE;
            phase_cnt = '0;
        end
    endfunction

    // Gap entry, chained straight into the second pulse when the gap is zero
    function automatic void start_gap(input logic [SAMPLE_W-1:0] smp);
        if (second_len == '0) begin
            phase     = CODE_IDLE;
            phase_cnt = '0;
        end else if (gap_len == '0) begin
            start_second(smp);
        end else begin
            phase     = CODE_GAP;
            phase_cnt = gap_len;
        end
    endfunction

    // One time step of the weld timer; queues the view it leaves behind
    task automatic advance_weld_step(input logic ms, input logic pt, input logic trig,
                                     input logic [SAMPLE_W-1:0] smp);
        t_weld_view  view;
        int unsigned threshold;
        // trigger tracking runs in every phase
        if (prev_trig && !trig) begin
            armed   = 1'b1;
            wait_ms = '0;
        end else if (trig) begin
            armed = 1'b0;
        end else if (armed && ms && wait_ms != '1) begin
            wait_ms = wait_ms + CNT_W'(1);
        end
        prev_trig = trig;

        case (phase)
            CODE_FIRST: begin
                if (pt && phase_cnt != '0) phase_cnt = phase_cnt - CNT_W'(1);
                if (phase_cnt == '0) start_gap(smp);
            end
            CODE_GAP: begin
                if (ms && phase_cnt != '0) phase_cnt = phase_cnt - CNT_W'(1);
                if (phase_cnt == '0) start_second(smp);
            end
            CODE_SECOND: begin
                if (pt && phase_cnt != '0) phase_cnt = phase_cnt - CNT_W'(1);
                if (phase_cnt == '0) phase = CODE_IDLE;
            end
            default: begin
                threshold = 32'(arm_secs) * MS_PER_SECOND;
                if (armed && 32'(wait_ms) >= threshold) begin
                    armed = 1'b0;
                    if (first_len != '0 || second_len != '0) begin
                        welds = welds + CNT_W'(1);
                        if (first_len != '0) begin
                            phase        = CODE_FIRST;
                            phase_cnt    = first_len;
                            held_current = smp;
                        end else begin
                            start_gap(smp);
                        end
                    end
                end
            end
        endcase

        view.drive = (phase == CODE_FIRST) || (phase == CODE_SECOND);
        view.buzz  = view.drive;
        view.total = welds;
        view.held  = held_current;
        view.ph    = phase;
        weld_views.push_back(view);
    endtask

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_weld_view want;
        if (!i_rst_n) begin
            first_len    = FIRST_TICKS_RST;
            second_len   = SECOND_TICKS_RST;
            gap_len      = GAP_MS_RST;
            arm_secs     = WAIT_SEC_RST;
            phase        = CODE_IDLE;
            armed        = 1'b0;
            prev_trig    = 1'b1;
            wait_ms      = '0;
            phase_cnt    = '0;
            welds        = '0;
            held_current = '0;
            weld_views.delete();
        end else begin
            // register writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FIRST_TICKS:  first_len  = i_cfg_wdata;
                    CFG_SECOND_TICKS: second_len = i_cfg_wdata;
                    CFG_GAP_MS:       gap_len    = i_cfg_wdata;
                    CFG_WAIT_SEC:     arm_secs   = i_cfg_wdata[WAIT_W-1:0];
                    default: ;
                endcase
            end

            if (i_req_valid && !i_req_stall)
                advance_weld_step(i_ms_strobe, i_pulse_strobe, i_trigger_level,
                                  i_current_sample);

            // compare against the oldest queued view
            if (i_res_valid && !i_res_stall) begin
                if (weld_views.size() == 0) begin
                    $error("result with no request outstanding");
                    mismatches++;
                end else begin
                    want = weld_views.pop_front();
                    check_field("weld_drive", 32'(want.drive), 32'(i_weld_drive));
                    check_field("buzzer_drive", 32'(want.buzz), 32'(i_buzzer_drive));
                    check_field("weld_total", 32'(want.total), 32'(i_weld_total));
                    check_field("captured_current", 32'(want.held),
                                32'(i_captured_current));
                    check_field("phase_now", 32'(want.ph), 32'(i_phase_now));
                end
            end

            if (i_closing && !leftover_seen) begin
                leftover_seen = 1'b1;
                if (weld_views.size() != 0) begin
                    $error("%0d expected results never arrived", weld_views.size());
                    mismatches++;
                end
            end
        end
    end

endmodule

/* tb/dual_pulse_weld_sequencer_test.sv */
module dual_pulse_weld_sequencer_test;
    import dpws_pkg::*;

    localparam int LIMIT_CYCLES  = 400000;
    localparam int HOLD_CYCLES   = 250;
    localparam int ITEMS_PER_SET = 80;
    localparam int NUM_SETS      = 11;
    localparam int HOLD_SET      = 2;
    localparam int QUIET_SET     = 4;
    localparam int EXTREME_SET   = 7;

    typedef struct packed {
        logic [CNT_W-1:0]  first;
        logic [CNT_W-1:0]  second;
        logic [CNT_W-1:0]  gap;
        logic [WAIT_W-1:0] arm_secs;
    } t_weld_setting;

    // Register settings, one per phase of the run
    localparam t_weld_setting SCHEDULE [NUM_SETS] = '{
        '{16'd3,     16'd2,     16'd2,     6'd0},
        '{16'd2,     16'd0,     16'd3,     6'd0},   // second pulse off
        '{16'd0,     16'd4,     16'd0,     6'd0},   // first pulse off, no gap
        '{16'd1,     16'd1,     16'd0,     6'd0},
        '{16'd4,     16'd3,     16'd6,     6'd0},
        '{16'd0,     16'd0,     16'd5,     6'd0},   // both pulses off
        '{16'd2,     16'd3,     16'd4,     6'd1},   // one-second arm time
        '{16'd65535, 16'd65535, 16'd65535, 6'd63},  // extremes, never reached
        '{16'd5,     16'd0,     16'd0,     6'd0},
        '{16'd2,     16'd5,     16'd1,     6'd0},
        '{16'd6,     16'd2,     16'd8,     6'd0}
    };

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CNT_W-1:0]    i_cfg_wdata;
    logic                i_valid;
    logic                o_stall;
    logic                i_ms_strobe;
    logic                i_pulse_strobe;
    logic                i_trigger_level;
    logic [SAMPLE_W-1:0] i_current_sample;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic                o_weld_drive;
    logic                o_buzzer_drive;
    logic [CNT_W-1:0]    o_weld_total;
    logic [SAMPLE_W-1:0] o_captured_current;
    logic [PHCODE_W-1:0] o_phase_now;

    logic                closing   = 1'b0;
    logic                quiet     = 1'b0;
    logic                hold_go   = 1'b0;
    logic                hold_used = 1'b0;
    int                  hold_left = 0;
    int                  n_sent    = 0;
    int                  n_recv    = 0;
    int                  cycle_count = 0;
    int                  fail_count;
    logic [PHCODE_W-1:0] last_phase = CODE_IDLE;

    dual_pulse_weld_sequencer u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_ms_strobe        (i_ms_strobe),
        .i_pulse_strobe     (i_pulse_strobe),
        .i_trigger_level    (i_trigger_level),
        .i_current_sample   (i_current_sample),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_weld_drive       (o_weld_drive),
        .o_buzzer_drive     (o_buzzer_drive),
        .o_weld_total       (o_weld_total),
        .o_captured_current (o_captured_current),
        .o_phase_now        (o_phase_now)
    );

    dual_pulse_weld_sequencer_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_req_valid        (i_valid),
        .i_req_stall        (o_stall),
        .i_ms_strobe        (i_ms_strobe),
        .i_pulse_strobe     (i_pulse_strobe),
        .i_trigger_level    (i_trigger_level),
        .i_current_sample   (i_current_sample),
        .i_res_valid        (o_valid),
        .i_res_stall        (i_stall),
        .i_weld_drive       (o_weld_drive),
        .i_buzzer_drive     (o_buzzer_drive),
        .i_weld_total       (o_weld_total),
        .i_captured_current (o_captured_current),
        .i_phase_now        (o_phase_now),
        .i_closing          (closing),
        .o_fail_count       (fail_count)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result side: random stalls, one long hold-off, a quiet stretch
    always @(posedge i_clk) begin
        if (o_valid && !i_stall) begin
            n_recv     <= n_recv + 1;
            last_phase <= o_phase_now;
        end
        if (hold_left != 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_go && !hold_used) begin
            i_stall   <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end else if (quiet) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(99) < 25);
        end
    end

    // Mostly random readings, with the rails now and then
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int unsigned r;
        r = $urandom_range(9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return SAMPLE_W'($urandom_range(4095));
    endfunction

    // Offer one request and wait until it is taken; valid stays high on return
    task automatic send_step(input logic ms, input logic pt, input logic trig,
                             input logic [SAMPLE_W-1:0] smp);
        if (!quiet && $urandom_range(99) < 25) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_ms_strobe      <= ms;
        i_pulse_strobe   <= pt;
        i_trigger_level  <= trig;
        i_current_sample <= smp;
        do @(posedge i_clk); while (o_stall);
        n_sent++;
    endtask

    // Stop offering and wait for every outstanding result
    task automatic settle();
        i_valid <= 1'b0;
        wait (n_recv == n_sent);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic load_setting(input t_weld_setting s);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_FIRST_TICKS;
        i_cfg_wdata <= s.first;
        @(posedge i_clk);
        i_cfg_idx   <= CFG_SECOND_TICKS;
        i_cfg_wdata <= s.second;
        @(posedge i_clk);
        i_cfg_idx   <= CFG_GAP_MS;
        i_cfg_wdata <= s.gap;
        @(posedge i_clk);
        i_cfg_idx   <= CFG_WAIT_SEC;
        i_cfg_wdata <= CNT_W'(s.arm_secs);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Release, press, then hold with random strobes; a few bounces break it up
    task automatic weld_attempt(input int unsigned hold_len);
        int unsigned k;
        repeat ($urandom_range(1, 3))
            send_step(1'($urandom_range(1)), 1'($urandom_range(1)), 1'b1, pick_sample());
        for (k = 0; k < hold_len; k++)
            send_step($urandom_range(99) < 60, $urandom_range(99) < 60,
                      $urandom_range(99) < 4, pick_sample());
    endtask

    initial begin : stimulus
        int p;
        int k;
        int start;
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = CFG_FIRST_TICKS;
        i_cfg_wdata      = '0;
        i_valid          = 1'b0;
        i_ms_strobe      = 1'b0;
        i_pulse_strobe   = 1'b0;
        i_trigger_level  = 1'b1;
        i_current_sample = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: every strobe and trigger combination, sample rails
        for (k = 0; k < 8; k++)
            send_step(k[0], k[1], k[2], k[0] ? '1 : '0);

        // Short weld with zero gap and zero arm time, pulses of one and two ticks
        settle();
        load_setting('{16'd2, 16'd1, 16'd0, 6'd0});
        send_step(1'b0, 1'b0, 1'b1, 12'h000);
        send_step(1'b0, 1'b0, 1'b0, 12'hFFF);   // press: starts at once
        send_step(1'b1, 1'b0, 1'b0, 12'h123);
        send_step(1'b0, 1'b1, 1'b0, 12'h456);
        send_step(1'b0, 1'b1, 1'b0, 12'hA5A);   // second pulse starts same step
        send_step(1'b1, 1'b1, 1'b0, 12'h5A5);
        send_step(1'b0, 1'b0, 1'b1, 12'h001);
        send_step(1'b1, 1'b1, 1'b0, 12'h800);
        send_step(1'b1, 1'b1, 1'b0, 12'h7FF);
        send_step(1'b1, 1'b1, 1'b0, 12'hFFE);
        send_step(1'b1, 1'b1, 1'b1, 12'h000);

        for (p = 0; p < NUM_SETS; p++) begin
            // block must sit idle before the unreachable lengths go in
            if (p == EXTREME_SET) begin
                do begin
                    send_step(1'b1, 1'b1, 1'b1, pick_sample());
                    i_valid <= 1'b0;
                    wait (n_recv == n_sent);
                    @(posedge i_clk);
                end while (last_phase != CODE_IDLE);
            end
            settle();
            load_setting(SCHEDULE[p]);
            quiet <= (p == QUIET_SET);
            if (p == HOLD_SET) hold_go <= 1'b1;
            start = n_sent;

            // full one-second press with a millisecond every step
            if (SCHEDULE[p].arm_secs == 6'd1) begin
                send_step(1'b0, 1'b0, 1'b1, pick_sample());
                repeat (1010)
                    send_step(1'b1, $urandom_range(99) < 70, 1'b0, pick_sample());
            end

            while (n_sent - start < ITEMS_PER_SET) begin
                if ($urandom_range(99) < 75)
                    weld_attempt($urandom_range(4, 30));
                else
                    send_step(1'($urandom_range(1)), 1'($urandom_range(1)),
                              1'($urandom_range(1)), SAMPLE_W'($urandom_range(4095)));
            end
        end

        i_valid <= 1'b0;
        wait (n_recv == n_sent);
        repeat (8) @(posedge i_clk);
        closing <= 1'b1;
        repeat (2) @(posedge i_clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* filelist.f */
hdl/dpws_pkg.sv
hdl/dpws_trigger.sv
hdl/dpws_phase.sv
hdl/dual_pulse_weld_sequencer.sv
tb/dual_pulse_weld_sequencer_checker.sv
tb/dual_pulse_weld_sequencer_test.sv
